@@ src/rfa_pkg.sv @@
// Shared types and constants for the ring fork arbiter.
// Holds the input and result word layouts, seat status codes and cell command codes.
// No dependencies.
`default_nettype none

package rfa_pkg;

  // Fixed field widths
  localparam int SEAT_FW = 4;
  localparam int MEAL_W  = 16;
  localparam int CFG_W   = 5;

  // Seat status codes
  localparam logic [1:0] ST_THINKING = 2'd0;
  localparam logic [1:0] ST_HUNGRY   = 2'd1;
  localparam logic [1:0] ST_EATING   = 2'd2;

  // Input word modes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Commands broadcast along the row of cells
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_TRY     = 2'd3;

  localparam logic [MEAL_W-1:0] MEAL_MAX    = '1;
  localparam logic [CFG_W-1:0]  SEATS_RESET = 5'd5;

  typedef struct packed {
    logic               mode;
    logic [SEAT_FW-1:0] seat;
  } item_t;

  typedef struct packed {
    logic [SEAT_FW-1:0] granted_seat;
    logic               granted;
    logic [MEAL_W-1:0]  meal_count;
    logic               bad_seat;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
  } cell_cmd_t;

  typedef struct packed {
    logic              eating;
    logic              grant;
    logic [MEAL_W-1:0] meals;
  } cell_stat_t;

endpackage

`default_nettype wire

@@ src/rfa_cell.sv @@
// One seat of the ring: status and saturating meal counter.
// Takes its neighbours' eating flags each cycle and shows its own; uses rfa_pkg.
`default_nettype none

module rfa_cell
  import rfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  logic       left_eating,
  input  logic       right_eating,
  output cell_stat_t stat
);

  logic [1:0]        status;
  logic [1:0]        status_next;
  logic [MEAL_W-1:0] meals;
  logic [MEAL_W-1:0] meals_next;
  logic              want;
  logic              grant;

  // Decide the grant and the next status for this seat
  always_comb begin
    want        = 1'b0;
    status_next = status;
    unique case (cmd.op)
      OP_REQUEST: want = 1'b1;
      OP_TRY:     want = (status == ST_HUNGRY);
      default:    want = 1'b0;
    endcase
    grant = cmd.hit && want && !left_eating && !right_eating;
    if (cmd.hit) begin
      unique case (cmd.op)
        OP_REQUEST: status_next = grant ? ST_EATING : ST_HUNGRY;
        OP_RELEASE: status_next = ST_THINKING;
        OP_TRY:     status_next = grant ? ST_EATING : status;
        default:    status_next = status;
      endcase
    end
    meals_next = (grant && (meals != MEAL_MAX)) ? meals + MEAL_W'(1) : meals;
  end

  // Hold seat state
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= ST_THINKING;
      meals  <= '0;
    end else begin
      status <= status_next;
      meals  <= meals_next;
    end
  end

  // Show state to the neighbours and the controller
  assign stat.eating = (status == ST_EATING);
  assign stat.grant  = grant;
  assign stat.meals  = meals_next;

endmodule

`default_nettype wire

@@ src/ring_fork_arbiter.sv @@
// Ring fork arbiter: a request word passes from acceptance through EXEC back to idle,
// its result shows in the cycle after the last busy cycle; a release word passes through
// EXEC, LEFT and RIGHT, and EMIT when both neighbours are granted, one neighbour test per state.
// Results show on result_valid for one cycle each, at most two per word, back to back.
// Synchronous active-high reset sets every seat thinking, all meal counts zero and
// the seat count to 5; the configuration port is always ready.
`default_nettype none

module ring_fork_arbiter
  import rfa_pkg::*;
#(
  parameter int MAX_SEATS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  item_t            item,
  output logic             busy,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output result_t          result,
  output logic             result_valid
);

  localparam int SEAT_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEATS + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LEFT  = 3'd2;
  localparam logic [2:0] S_RIGHT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state;
  logic [CFG_W-1:0]   seats_in_use;
  item_t              item_q;
  logic [SEAT_FW-1:0] pend_seat;
  logic [MEAL_W-1:0]  pend_meal;
  logic               pend_granted;

  logic [CW-1:0]      cfg_ext;
  logic [CW-1:0]      ring_n;
  logic [CW-1:0]      ring_last;
  logic [CW-1:0]      seat_ext;
  logic [CW-1:0]      left_pos;
  logic [CW-1:0]      right_pos;
  logic [CW-1:0]      target_pos;
  logic [SEAT_W-1:0]  target_idx;
  logic [SEAT_W-1:0]  last_idx;
  logic [1:0]         op;
  logic               bad;

  cell_cmd_t          cmd  [MAX_SEATS];
  cell_stat_t         stat [MAX_SEATS];
  logic [MAX_SEATS-1:0] eat;
  cell_stat_t         sel;

  // Clamp the seat count into the supported range
  always_comb begin
    cfg_ext = CW'(seats_in_use);
    if (cfg_ext < CW'(2)) begin
      ring_n = CW'(2);
    end else if (cfg_ext > CW'(MAX_SEATS)) begin
      ring_n = CW'(MAX_SEATS);
    end else begin
      ring_n = cfg_ext;
    end
  end

  assign ring_last = ring_n - CW'(1);
  assign last_idx  = ring_last[SEAT_W-1:0];
  assign seat_ext  = CW'(item_q.seat);
  assign bad       = (seat_ext >= ring_n);
  assign left_pos  = ((seat_ext + CW'(1)) >= ring_n) ? '0 : seat_ext + CW'(1);
  assign right_pos = (seat_ext == '0) ? ring_last : seat_ext - CW'(1);

  // Pick the seat and command for this step
  always_comb begin
    target_pos = seat_ext;
    op         = OP_NONE;
    unique case (state)
      S_EXEC: begin
        target_pos = seat_ext;
        if (!bad) begin
          op = (item_q.mode == MODE_RELEASE) ? OP_RELEASE : OP_REQUEST;
        end
      end
      S_LEFT: begin
        target_pos = left_pos;
        op         = OP_TRY;
      end
      S_RIGHT: begin
        target_pos = right_pos;
        op         = OP_TRY;
      end
      default: begin
        target_pos = seat_ext;
        op         = OP_NONE;
      end
    endcase
  end

  assign target_idx = target_pos[SEAT_W-1:0];

  // Row of seat cells, each wired to its ring neighbours
  for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
    logic left_eating;
    logic right_eating;

    assign cmd[i].op  = op;
    assign cmd[i].hit = (target_idx == SEAT_W'(i));
    assign eat[i]     = stat[i].eating;

    assign left_eating = (CW'(i + 1) >= ring_n) ? eat[0] : eat[(i + 1) % MAX_SEATS];
    if (i == 0) begin : g_wrap
      assign right_eating = eat[last_idx];
    end else begin : g_inner
      assign right_eating = eat[i - 1];
    end

    rfa_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd[i]),
      .left_eating  (left_eating),
      .right_eating (right_eating),
      .stat         (stat[i])
    );
  end

  assign sel       = stat[target_idx];
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Advance the sequencer, strobe results, take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      seats_in_use <= SEATS_RESET;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        seats_in_use <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (bad || (item_q.mode == MODE_REQUEST)) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
          end else begin
            state <= S_LEFT;
          end
        end
        S_LEFT: state <= S_RIGHT;
        S_RIGHT: begin
          result_valid <= 1'b1;
          state        <= (sel.grant && pend_granted) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the word, the pending result and the output word
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          item_q <= item;
        end
      end
      S_EXEC: begin
        if (bad) begin
          result.granted_seat <= item_q.seat;
          result.granted      <= 1'b0;
          result.meal_count   <= '0;
          result.bad_seat     <= 1'b1;
          result.last         <= 1'b1;
        end else if (item_q.mode == MODE_REQUEST) begin
          result.granted_seat <= item_q.seat;
          result.granted      <= sel.grant;
          result.meal_count   <= sel.meals;
          result.bad_seat     <= 1'b0;
          result.last         <= 1'b1;
        end else begin
          pend_seat    <= item_q.seat;
          pend_meal    <= sel.meals;
          pend_granted <= 1'b0;
        end
      end
      S_LEFT: begin
        if (sel.grant) begin
          pend_seat    <= target_pos[SEAT_FW-1:0];
          pend_meal    <= sel.meals;
          pend_granted <= 1'b1;
        end
      end
      S_RIGHT: begin
        if (sel.grant && pend_granted) begin
          result.granted_seat <= pend_seat;
          result.granted      <= 1'b1;
          result.meal_count   <= pend_meal;
          result.bad_seat     <= 1'b0;
          result.last         <= 1'b0;
          pend_seat           <= target_pos[SEAT_FW-1:0];
          pend_meal           <= sel.meals;
        end else if (sel.grant) begin
          result.granted_seat <= target_pos[SEAT_FW-1:0];
          result.granted      <= 1'b1;
          result.meal_count   <= sel.meals;
          result.bad_seat     <= 1'b0;
          result.last         <= 1'b1;
        end else begin
          result.granted_seat <= pend_seat;
          result.granted      <= pend_granted;
          result.meal_count   <= pend_meal;
          result.bad_seat     <= 1'b0;
          result.last         <= 1'b1;
        end
      end
      S_EMIT: begin
        result.granted_seat <= pend_seat;
        result.granted      <= 1'b1;
        result.meal_count   <= pend_meal;
        result.bad_seat     <= 1'b0;
        result.last         <= 1'b1;
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/rfa_checker.sv @@
// Port-level checks for the ring fork arbiter, attached by bind.
// Depends on rfa_pkg and the ring_fork_arbiter top level.
`default_nettype none

module rfa_checker
  import rfa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input result_t result,
  input logic    result_valid
);

  // A rejected seat ends its word and grants nothing
  a_bad_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_seat |-> result.last && !result.granted)
    else $error("bad seat word not final or granted");

  // A word that is not final is always a grant
  a_mid_grant: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.granted && !result.bad_seat)
    else $error("non-final word without grant");

  // The second word follows the first at once
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid && result.last)
    else $error("second word missing");

  // A grant always shows a non-zero meal count
  a_grant_counts: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.granted |-> result.meal_count != '0)
    else $error("grant with zero meal count");

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy after acceptance");

endmodule

bind ring_fork_arbiter rfa_checker u_rfa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);

`default_nettype wire
